>>> rtl/assert_macros.svh
// assertion helpers for the command recogniser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define JCBR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("jcbr assertion failed");

// two signals that must never be high together
`define JCBR_ASSERT_EXCL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) \
    else $error("jcbr exclusive signals both high");

`else

`define JCBR_ASSERT(label, clk, rst_n, prop)
`define JCBR_ASSERT_EXCL(label, clk, rst_n, a, b)

`endif

`endif

>>> rtl/jcbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jcbr_pkg;

  localparam int unsigned WinLen = 13;
  localparam int unsigned WinW   = WinLen * 8;
  localparam int unsigned UpdLen = 12;
  localparam int unsigned UpdW   = UpdLen * 8;

  localparam logic [WinW-1:0] GetAllWord = "getAllSensors";
  localparam logic [UpdW-1:0] UpdateWord = "updateSensor";

  localparam logic [7:0] ByteF     = 8'h66;  // 'f'
  localparam logic [7:0] ByteQuote = 8'h22;  // '"'
  localparam logic [7:0] ByteColon = 8'h3A;  // ':'
  localparam logic [7:0] ByteBang  = 8'h21;  // '!'

  localparam logic [3:0] WinCmpCount = 4'd14;
  localparam logic [7:0] CapLetter   = 8'd9;
  localparam logic [7:0] CapDigit    = 8'd10;
  localparam logic [7:0] CapValue    = 8'd19;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_F      = 3'd1,
    PH_QUOTE  = 3'd2,
    PH_COLON  = 3'd3,
    PH_TAIL   = 3'd4,
    PH_GETALL = 3'd6,
    PH_UPDATE = 3'd7
  } phase_e;

  // window status towards the control
  typedef struct packed {
    logic full;
    logic get_match;
    logic upd_match;
  } win_stat_t;

  // one result
  typedef struct packed {
    logic       get_all_hit;
    logic       update_hit;
    logic [7:0] sensor_letter;
    logic [7:0] sensor_digit;
    logic [7:0] sensor_value;
    logic [2:0] parse_phase;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/json_command_byte_recognizer.sv
// channel   | valid       | ready       | payload
// ----------+-------------+-------------+-------------------------------------
// rx        | rx_valid_i  | rx_ready_o  | rx_byte_i
// res       | res_valid_o | res_ready_i | get_all_hit_o .. parse_phase_o
//
// one byte per cycle while the result side is not stalled: each accepted request
// is evaluated by combinational compare logic (13-byte window compare and the hunt
// machine) and its result lands in the output register on the same edge.
// reset clears the phase, window, counters, captures and the output valid.
// a stalled result holds the output register; a new request is still taken
// in the cycle the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module json_command_byte_recognizer import jcbr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic            get_all_hit_o,
  output logic            update_hit_o,
  output logic [7:0]      sensor_letter_o,
  output logic [7:0]      sensor_digit_o,
  output logic [7:0]      sensor_value_o,
  output logic [2:0]      parse_phase_o
);

  logic      accept;
  logic      shift, bang;
  win_stat_t win_stat;
  res_t      res_d, res_q;
  logic      res_valid_q;

  // take a request whenever the output register is empty or being drained
  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign accept     = rx_valid_i && rx_ready_o;

  // shift window, fourteenth-shift compare
  jcbr_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (accept && shift),
    .clear_i (accept && bang),
    .byte_i  (rx_byte_i),
    .stat_o  (win_stat)
  );

  // hunt machine, command phases, captures
  jcbr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (rx_byte_i),
    .win_i    (win_stat),
    .shift_o  (shift),
    .bang_o   (bang),
    .res_o    (res_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      res_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign get_all_hit_o   = res_q.get_all_hit;
  assign update_hit_o    = res_q.update_hit;
  assign sensor_letter_o = res_q.sensor_letter;
  assign sensor_digit_o  = res_q.sensor_digit;
  assign sensor_value_o  = res_q.sensor_value;
  assign parse_phase_o   = res_q.parse_phase;

  // an accepted request always yields a result next cycle
  `JCBR_ASSERT(a_accept_gives_result, clk_i, rst_ni, accept |=> res_valid_q)
  // a completed update command always drops back to idle
  `JCBR_ASSERT(a_update_ends_idle, clk_i, rst_ni,
               (res_valid_q && res_q.update_hit) |-> (res_q.parse_phase == PH_IDLE))
  // the two command hits never coincide
  `JCBR_ASSERT_EXCL(a_hits_exclusive, clk_i, rst_ni,
                    res_valid_q && res_q.get_all_hit, res_q.update_hit)

endmodule

`default_nettype wire

>>> rtl/jcbr_window.sv
`timescale 1ns / 1ps
`default_nettype none

module jcbr_window import jcbr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      shift_i,
  input  wire logic      clear_i,
  input  wire logic [7:0] byte_i,
  output win_stat_t      stat_o
);

  logic [WinW-1:0] win_q, win_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [3:0]      cnt_inc;

  // oldest byte in the top bits
  assign win_d   = {win_q[WinW-9:0], byte_i};
  assign cnt_inc = cnt_q + 4'd1;

  assign stat_o.full      = (cnt_inc == WinCmpCount);
  assign stat_o.get_match = (win_d == GetAllWord);
  assign stat_o.upd_match = (win_d[WinW-1:WinW-UpdW] == UpdateWord);

  always_comb begin
    cnt_d = cnt_q;
    if (shift_i) begin
      cnt_d = stat_o.full ? 4'd0 : cnt_inc;
    end
    if (clear_i) begin
      cnt_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (shift_i) begin
        win_q <= win_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/jcbr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module jcbr_ctrl import jcbr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire win_stat_t  win_i,
  output logic            shift_o,
  output logic            bang_o,
  output res_t            res_o
);

  phase_e     phase_q, phase_d, phase_hunt, phase_win;
  logic [7:0] ucnt_q, ucnt_d, ucnt_inc;
  logic [7:0] cap_letter_q, cap_letter_d;
  logic [7:0] cap_digit_q, cap_digit_d;
  logic [7:0] cap_value_q, cap_value_d;
  logic       get_hit, upd_hit;

  assign bang_o   = (byte_i == ByteBang);
  assign ucnt_inc = ucnt_q + 8'd1;

  // key tail hunt, any 'f' restarts
  always_comb begin
    phase_hunt = phase_q;
    if (byte_i == ByteF) begin
      phase_hunt = PH_F;
    end else begin
      unique case (phase_q)
        PH_F:     phase_hunt = (byte_i == ByteQuote) ? PH_QUOTE : PH_IDLE;
        PH_QUOTE: phase_hunt = (byte_i == ByteColon) ? PH_COLON : PH_IDLE;
        PH_COLON: phase_hunt = (byte_i == ByteQuote) ? PH_TAIL : PH_IDLE;
        default:  phase_hunt = phase_q;
      endcase
    end
  end

  // window verdict on the fourteenth shift
  always_comb begin
    phase_win = phase_hunt;
    if (phase_hunt == PH_TAIL && win_i.full) begin
      if (win_i.get_match) begin
        phase_win = PH_GETALL;
      end else if (win_i.upd_match) begin
        phase_win = PH_UPDATE;
      end else begin
        phase_win = PH_IDLE;
      end
    end
  end

  // next state
  always_comb begin
    phase_d = phase_win;
    if (phase_win == PH_UPDATE && ucnt_inc == CapValue) begin
      phase_d = PH_IDLE;
    end
    if (bang_o) begin
      phase_d = PH_IDLE;
    end
  end

  // outputs and data path
  always_comb begin
    shift_o      = (phase_hunt == PH_TAIL);
    get_hit      = (phase_win == PH_GETALL);
    upd_hit      = 1'b0;
    ucnt_d       = ucnt_q;
    cap_letter_d = cap_letter_q;
    cap_digit_d  = cap_digit_q;
    cap_value_d  = cap_value_q;
    if (phase_win == PH_UPDATE) begin
      ucnt_d = ucnt_inc;
      if (ucnt_inc == CapLetter) begin
        cap_letter_d = byte_i;
      end else if (ucnt_inc == CapDigit) begin
        cap_digit_d = byte_i;
      end else if (ucnt_inc == CapValue) begin
        cap_value_d = byte_i;
        upd_hit     = 1'b1;
      end
    end
    if (bang_o) begin
      ucnt_d = 8'd0;
    end
  end

  assign res_o.get_all_hit   = get_hit;
  assign res_o.update_hit    = upd_hit;
  assign res_o.sensor_letter = cap_letter_d;
  assign res_o.sensor_digit  = cap_digit_d;
  assign res_o.sensor_value  = cap_value_d;
  assign res_o.parse_phase   = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      ucnt_q       <= '0;
      cap_letter_q <= '0;
      cap_digit_q  <= '0;
      cap_value_q  <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      ucnt_q       <= ucnt_d;
      cap_letter_q <= cap_letter_d;
      cap_digit_q  <= cap_digit_d;
      cap_value_q  <= cap_value_d;
    end
  end

endmodule

`default_nettype wire

>>> verif/json_command_byte_recognizer_tb.sv
`timescale 1ns / 1ps

module json_command_byte_recognizer_tb;
  import jcbr_pkg::*;

  // run limits and pressure
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;

  logic       clk_i;
  logic       rst_ni;
  logic       rx_valid_i;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i;
  logic       res_valid_o;
  logic       res_ready_i;
  logic       get_all_hit_o;
  logic       update_hit_o;
  logic [7:0] sensor_letter_o;
  logic [7:0] sensor_digit_o;
  logic [7:0] sensor_value_o;
  logic [2:0] parse_phase_o;

  json_command_byte_recognizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .get_all_hit_o  (get_all_hit_o),
    .update_hit_o   (update_hit_o),
    .sensor_letter_o(sensor_letter_o),
    .sensor_digit_o (sensor_digit_o),
    .sensor_value_o (sensor_value_o),
    .parse_phase_o  (parse_phase_o)
  );

  // shadow copy of the recogniser state, updated once per accepted request
  phase_e          ph_shadow     = PH_IDLE;
  logic [WinW-1:0] win_shadow    = '0;  // oldest byte in the top lane
  logic [3:0]      win_cnt       = '0;
  logic [7:0]      upd_cnt       = '0;
  logic [7:0]      cap_letter    = '0;
  logic [7:0]      cap_digit     = '0;
  logic [7:0]      cap_value     = '0;

  res_t pending_q[$];  // results owed by the block, oldest first
  res_t oldest_res;
  int   fail_cnt      = 0;
  int   n_sent        = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_req      = 1'b0;

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop if the run hangs
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // work out the result of one byte and advance the shadow state
  function automatic res_t recognise_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    // key tail hunt, an 'f' restarts it from any phase
    if (b == ByteF) begin
      ph_shadow = PH_F;
    end else if (ph_shadow == PH_F) begin
      ph_shadow = (b == ByteQuote) ? PH_QUOTE : PH_IDLE;
    end else if (ph_shadow == PH_QUOTE) begin
      ph_shadow = (b == ByteColon) ? PH_COLON : PH_IDLE;
    end else if (ph_shadow == PH_COLON) begin
      ph_shadow = (b == ByteQuote) ? PH_TAIL : PH_IDLE;
    end
    // window shift, compared on every 14th shift only
    if (ph_shadow == PH_TAIL) begin
      win_shadow = {win_shadow[WinW-9:0], b};
      win_cnt    = win_cnt + 4'd1;
      if (win_cnt == WinCmpCount) begin
        win_cnt = '0;
        if (win_shadow == GetAllWord) begin
          ph_shadow = PH_GETALL;
        end else if (win_shadow[WinW-1 -: UpdW] == UpdateWord) begin
          ph_shadow = PH_UPDATE;
        end else begin
          ph_shadow = PH_IDLE;
        end
      end
    end
    // command handling, runs on the matching byte as well
    if (ph_shadow == PH_GETALL) begin
      r.get_all_hit = 1'b1;
    end else if (ph_shadow == PH_UPDATE) begin
      upd_cnt = upd_cnt + 8'd1;
      if (upd_cnt == CapLetter) begin
        cap_letter = b;
      end else if (upd_cnt == CapDigit) begin
        cap_digit = b;
      end else if (upd_cnt == CapValue) begin
        cap_value      = b;
        r.update_hit   = 1'b1;
        ph_shadow      = PH_IDLE;
      end
    end
    // bang acts last, so a hit in the same step still shows
    if (b == ByteBang) begin
      ph_shadow = PH_IDLE;
      win_cnt   = '0;
      upd_cnt   = '0;
    end
    r.sensor_letter = cap_letter;
    r.sensor_digit  = cap_digit;
    r.sensor_value  = cap_value;
    r.parse_phase   = ph_shadow;
    return r;
  endfunction

  task automatic compare_result(input res_t want, input res_t got);
    if (got.get_all_hit !== want.get_all_hit) begin
      $error("get_all_hit: expected %0d, got %0d", want.get_all_hit, got.get_all_hit);
      fail_cnt++;
    end
    if (got.update_hit !== want.update_hit) begin
      $error("update_hit: expected %0d, got %0d", want.update_hit, got.update_hit);
      fail_cnt++;
    end
    if (got.sensor_letter !== want.sensor_letter) begin
      $error("sensor_letter: expected %h, got %h", want.sensor_letter, got.sensor_letter);
      fail_cnt++;
    end
    if (got.sensor_digit !== want.sensor_digit) begin
      $error("sensor_digit: expected %h, got %h", want.sensor_digit, got.sensor_digit);
      fail_cnt++;
    end
    if (got.sensor_value !== want.sensor_value) begin
      $error("sensor_value: expected %h, got %h", want.sensor_value, got.sensor_value);
      fail_cnt++;
    end
    if (got.parse_phase !== want.parse_phase) begin
      $error("parse_phase: expected %0d, got %0d", want.parse_phase, got.parse_phase);
      fail_cnt++;
    end
  endtask

  // sample both handshakes on the edge; retire a result before logging a new request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        if (pending_q.size() == 0) begin
          $error("result arrived with nothing outstanding");
          fail_cnt++;
        end else begin
          oldest_res = pending_q.pop_front();
          compare_result(oldest_res, {get_all_hit_o, update_hit_o, sensor_letter_o,
                                      sensor_digit_o, sensor_value_o, parse_phase_o});
        end
      end
      if (rx_valid_i && rx_ready_o) begin
        pending_q.push_back(recognise_byte(rx_byte_i));
      end
    end
  end

  // result side: random back-pressure, or a long hold when one is asked for
  initial begin
    res_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        res_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one request, with random gaps before it, and wait for acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    n_sent++;
  endtask

  // any byte that neither restarts the hunt nor clears the counters
  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom); while (v == ByteF || v == ByteBang);
    return v;
  endfunction

  // payload byte with an occasional restart or bang mixed in
  function automatic logic [7:0] payload_byte();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3) return ByteF;
    if (p < 6) return ByteBang;
    return plain_byte();
  endfunction

  // key tail then a command name; bad_pos flips one bit of that name byte
  task automatic send_command(input bit want_get, input int bad_pos);
    logic [7:0] ch;
    send_byte(ByteF);
    send_byte(ByteQuote);
    send_byte(ByteColon);
    send_byte(ByteQuote);
    for (int i = 0; i < WinLen; i++) begin
      if (want_get) begin
        ch = GetAllWord[WinW-1-8*i -: 8];
      end else if (i < UpdLen) begin
        ch = UpdateWord[UpdW-1-8*i -: 8];
      end else begin
        ch = plain_byte();
      end
      if (i == bad_pos) ch = ch ^ 8'h01;
      send_byte(ch);
    end
  endtask

  // field extremes and broken key tails
  task automatic test_extremes();
    send_byte(ByteBang);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ByteF);
    send_byte(ByteQuote);
    send_byte(ByteColon);
    send_byte(8'h78);
    send_byte(ByteF);
    send_byte(ByteQuote);
    send_byte(8'h78);
  endtask

  // get-all match, hit on the following bytes, restart out of it, then bang
  task automatic test_get_all();
    send_byte(ByteBang);
    send_command(1'b1, -1);
    send_byte(plain_byte());
    send_byte(plain_byte());
    send_byte(ByteF);
    send_byte(ByteBang);
  endtask

  // update match with a bang as the value byte: capture and clear in one step
  task automatic test_update_capture();
    send_byte(ByteBang);
    send_command(1'b0, -1);
    repeat (17) send_byte(plain_byte());
    send_byte(ByteBang);
    send_byte(plain_byte());
  endtask

  // second update without a bang: the count carries on and wraps past 255
  task automatic test_count_wrap();
    send_byte(ByteBang);
    send_command(1'b0, -1);
    repeat (18) send_byte(plain_byte());
    send_command(1'b0, -1);
    repeat (260) send_byte(plain_byte());
  endtask

  // one random sequence: mostly well-formed commands, some noise and breakage
  task automatic send_sequence();
    int unsigned pick;
    bit          want_get;
    int          bad_pos;
    int unsigned tail_len;
    pick = $urandom_range(99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
    end else if (pick < 20) begin
      // key tail broken part way
      send_byte(ByteF);
      send_byte(ByteQuote);
      send_byte(8'($urandom));
    end else begin
      if ($urandom_range(3) != 0) send_byte(ByteBang);
      want_get = ($urandom_range(99) < 40);
      bad_pos  = ($urandom_range(9) == 0) ? int'($urandom_range(WinLen - 1)) : -1;
      send_command(want_get, bad_pos);
      tail_len = want_get ? $urandom_range(0, 6) : $urandom_range(18, 21);
      repeat (tail_len) send_byte(payload_byte());
    end
  endtask

  task automatic test_random(input int target);
    while (n_sent < target) send_sequence();
  endtask

  // result side held off for a long stretch while requests keep coming
  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (3) send_sequence();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    rx_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender gaps light, receiver stalls heavy
    send_idle_pct = 31;
    recv_idle_pct = 54;
    test_extremes();
    test_get_all();
    test_update_capture();
    test_count_wrap();
    test_random(700);

    // the other way round
    send_idle_pct = 54;
    recv_idle_pct = 31;
    test_output_stall();
    test_random(1050);

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(1450);

    rx_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
